// ===== rtl/fts_pkg.sv =====
// fts_pkg: shared types and constants for the frame-time percentile summary
// holds the controller command/status structs, the state enum and rank constants
// no dependencies
package fts_pkg;

	// width of every time field on the ports
	localparam int unsigned OUT_W = 32;

	// quantile numerators over 100 and the ceiling bias
	localparam int unsigned Q50      = 50;
	localparam int unsigned Q95      = 95;
	localparam int unsigned Q99      = 99;
	localparam int unsigned RANK_DEN = 100;
	localparam int unsigned RANK_BIAS = 99;
	localparam int unsigned Q_W      = 7;

	// divide by 100 as multiply by ceil(2^30/100) and shift, exact below about 2^23
	localparam int unsigned       RCP_SH = 30;
	localparam int unsigned       RCP_W  = 24;
	localparam logic [RCP_W-1:0]  RCP_K  = 24'd10737419;

	// number of order-statistic selectors: best, p50, p95, p99, worst
	localparam int unsigned NSEL    = 5;
	localparam int unsigned SEL_MIN = 0;
	localparam int unsigned SEL_P50 = 1;
	localparam int unsigned SEL_P95 = 2;
	localparam int unsigned SEL_P99 = 3;
	localparam int unsigned SEL_MAX = 4;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_SEL_GO,
		ST_SEL_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic    load;
		logic    div_start;
		logic    sel_start;
		logic    emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic sel_done;
	} dp_status_t;

endpackage

// ===== rtl/fts_div.sv =====
// fts_div: restoring divider, one quotient bit per cycle
// uses fts_pkg only for house consistency of imports
module fts_div import fts_pkg::*; #(
	parameter int unsigned DD_W = 42,
	parameter int unsigned DV_W = 11
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DD_W-1:0] dividend,
	input  logic [DV_W-1:0] divisor,
	output logic            done,
	output logic [DD_W-1:0] quotient
);

	localparam int unsigned CW = $clog2(DD_W + 1);

	logic [DV_W-1:0] rem_q;
	logic [DD_W-1:0] quo_q;
	logic [DV_W-1:0] dvs_q;
	logic [CW-1:0]   cnt_q;
	logic            run_q;
	logic            done_q;
	logic [DV_W:0]   trial;
	logic            fits;

	// trial subtract of the next partial remainder
	assign trial = {rem_q, quo_q[DD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= DV_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[DV_W-1:0];
			end
			quo_q <= {quo_q[DD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/fts_datapath.sv =====
// fts_datapath: sample store, run counters, divider and bitwise rank selectors
// depends on fts_pkg and fts_div
module fts_datapath import fts_pkg::*; #(
	parameter int unsigned MAX_SAMPLES = 1024,
	parameter int unsigned SAMPLE_BITS = 32,
	parameter int unsigned CNT_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_cmd_t        cmd,
	output dp_status_t       status,
	input  logic [OUT_W-1:0] sample_us,
	output logic [OUT_W-1:0] mean_us,
	output logic [OUT_W-1:0] median_us,
	output logic [OUT_W-1:0] p95_us,
	output logic [OUT_W-1:0] p99_us,
	output logic [OUT_W-1:0] best_us,
	output logic [OUT_W-1:0] worst_us,
	output logic [CNT_W-1:0] sample_count,
	output logic             overflowed
);

	localparam int unsigned AW    = $clog2(MAX_SAMPLES);
	localparam int unsigned SUM_W = SAMPLE_BITS + CNT_W;
	localparam int unsigned RK_W  = CNT_W + Q_W;

	logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];

	logic [CNT_W-1:0]       n_q;
	logic [SUM_W-1:0]       sum_q;
	logic                   drop_q;
	logic [SAMPLE_BITS+OUT_W-1:0] in_wide;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   has_room;

	// trim or widen the incoming sample
	assign in_wide  = {{SAMPLE_BITS{1'b0}}, sample_us};
	assign sample   = in_wide[SAMPLE_BITS-1:0];
	assign has_room = n_q < CNT_W'(MAX_SAMPLES);

	// run counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			sum_q  <= '0;
			drop_q <= 1'b0;
		end else if (cmd.emit) begin
			n_q    <= '0;
			sum_q  <= '0;
			drop_q <= 1'b0;
		end else if (cmd.load) begin
			if (has_room) begin
				n_q   <= n_q + 1'b1;
				sum_q <= sum_q + SUM_W'(sample);
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

	// ranks ceil(n*q/100) as (n*q + 99) / 100, the divide by reciprocal, two stages
	logic [RK_W-1:0]       m50_q, m95_q, m99_q;
	logic [RK_W+RCP_W-1:0] p50, p95, p99;
	logic [CNT_W-1:0]      r50_q, r95_q, r99_q;

	assign p50 = {{RCP_W{1'b0}}, m50_q} * {{RK_W{1'b0}}, RCP_K};
	assign p95 = {{RCP_W{1'b0}}, m95_q} * {{RK_W{1'b0}}, RCP_K};
	assign p99 = {{RCP_W{1'b0}}, m99_q} * {{RK_W{1'b0}}, RCP_K};

	always_ff @(posedge clk) begin
		m50_q <= RK_W'(n_q) * RK_W'(Q50) + RK_W'(RANK_BIAS);
		m95_q <= RK_W'(n_q) * RK_W'(Q95) + RK_W'(RANK_BIAS);
		m99_q <= RK_W'(n_q) * RK_W'(Q99) + RK_W'(RANK_BIAS);
		r50_q <= p50[RCP_SH +: CNT_W];
		r95_q <= p95[RCP_SH +: CNT_W];
		r99_q <= p99[RCP_SH +: CNT_W];
	end

	// mean divider
	logic             div_done;
	logic [SUM_W-1:0] quo;
	logic [SUM_W-1:0] mean_q;

	fts_div #(.DD_W(SUM_W), .DV_W(CNT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (div_done) begin
			mean_q <= quo;
		end
	end

	// scan address generator, one store read per cycle
	logic [AW-1:0]          rd_addr_q;
	logic                   rd_act_q;
	logic                   rd_last;
	logic [SAMPLE_BITS-1:0] rdata_s1;
	logic                   rvalid_s1;
	logic                   rlast_s1;
	logic [CNT_W-1:0]       n_m1;

	assign n_m1    = n_q - 1'b1;
	assign rd_last = rd_addr_q == n_m1[AW-1:0];

	// sample store
	always_ff @(posedge clk) begin
		if (cmd.load && has_room) begin
			mem[n_q[AW-1:0]] <= sample;
		end
		rdata_s1 <= mem[rd_addr_q];
	end

	// bitwise selection state, one pass per sample bit
	logic [SAMPLE_BITS-1:0] mask_q;
	logic [SAMPLE_BITS-1:0] bit_q;
	logic [SAMPLE_BITS-1:0] pre_q [NSEL];
	logic [CNT_W-1:0]       k_q   [NSEL];
	logic [CNT_W-1:0]       cnt_q [NSEL];
	logic [CNT_W-1:0]       cnt_nx [NSEL];
	logic                   sel_done_q;
	logic                   pass_end;

	assign pass_end = rvalid_s1 && rlast_s1;

	always_comb begin
		for (int i = 0; i < NSEL; i++) begin
			cnt_nx[i] = cnt_q[i];
			if (rvalid_s1 && (((rdata_s1 ^ pre_q[i]) & mask_q) == '0)
				&& ((rdata_s1 & bit_q) == '0)) begin
				cnt_nx[i] = cnt_q[i] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_act_q   <= 1'b0;
			rvalid_s1  <= 1'b0;
			rlast_s1   <= 1'b0;
			sel_done_q <= 1'b0;
			rd_addr_q  <= '0;
		end else begin
			sel_done_q <= 1'b0;
			rvalid_s1  <= rd_act_q;
			rlast_s1   <= rd_act_q && rd_last;
			if (cmd.sel_start) begin
				rd_act_q  <= 1'b1;
				rd_addr_q <= '0;
			end else if (rd_act_q) begin
				rd_addr_q <= rd_addr_q + 1'b1;
				if (rd_last) begin
					rd_act_q <= 1'b0;
				end
			end else if (pass_end) begin
				if (bit_q[0]) begin
					sel_done_q <= 1'b1;
				end else begin
					rd_act_q  <= 1'b1;
					rd_addr_q <= '0;
				end
			end
		end
	end

	// selector lanes
	always_ff @(posedge clk) begin
		if (cmd.sel_start) begin
			mask_q <= '0;
			bit_q  <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			for (int i = 0; i < NSEL; i++) begin
				pre_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			k_q[SEL_MIN] <= CNT_W'(1);
			k_q[SEL_P50] <= r50_q;
			k_q[SEL_P95] <= r95_q;
			k_q[SEL_P99] <= r99_q;
			k_q[SEL_MAX] <= n_q;
		end else if (pass_end) begin
			mask_q <= {1'b1, mask_q[SAMPLE_BITS-1:1]};
			bit_q  <= {1'b0, bit_q[SAMPLE_BITS-1:1]};
			for (int i = 0; i < NSEL; i++) begin
				cnt_q[i] <= '0;
				if (k_q[i] > cnt_nx[i]) begin
					pre_q[i] <= pre_q[i] | bit_q;
					k_q[i]   <= k_q[i] - cnt_nx[i];
				end
			end
		end else begin
			for (int i = 0; i < NSEL; i++) begin
				cnt_q[i] <= cnt_nx[i];
			end
		end
	end

	// result formatting to port widths
	logic [SAMPLE_BITS+OUT_W-1:0] w_min, w_p50, w_p95, w_p99, w_max;
	logic [SUM_W+OUT_W-1:0]       w_mean;

	assign w_min  = {{OUT_W{1'b0}}, pre_q[SEL_MIN]};
	assign w_p50  = {{OUT_W{1'b0}}, pre_q[SEL_P50]};
	assign w_p95  = {{OUT_W{1'b0}}, pre_q[SEL_P95]};
	assign w_p99  = {{OUT_W{1'b0}}, pre_q[SEL_P99]};
	assign w_max  = {{OUT_W{1'b0}}, pre_q[SEL_MAX]};
	assign w_mean = {{OUT_W{1'b0}}, mean_q};

	assign mean_us      = w_mean[OUT_W-1:0];
	assign median_us    = w_p50[OUT_W-1:0];
	assign p95_us       = w_p95[OUT_W-1:0];
	assign p99_us       = w_p99[OUT_W-1:0];
	assign best_us      = w_min[OUT_W-1:0];
	assign worst_us     = w_max[OUT_W-1:0];
	assign sample_count = n_q;
	assign overflowed   = drop_q;

	assign status.div_done = div_done;
	assign status.sel_done = sel_done_q;

endmodule

// ===== rtl/fts_ctrl.sv =====
// fts_ctrl: run sequencer for load, mean divide, selection passes and result strobe
// depends on fts_pkg
module fts_ctrl import fts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       run_end,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	state_t  state_q, state_nx;
	logic    accept;

	assign accept = start && (state_q == ST_LOAD);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_LOAD:     if (accept && run_end) state_nx = ST_DIV_GO;
			ST_DIV_GO:   state_nx = ST_DIV_WAIT;
			ST_DIV_WAIT: if (status.div_done) state_nx = ST_SEL_GO;
			ST_SEL_GO:   state_nx = ST_SEL_WAIT;
			ST_SEL_WAIT: if (status.sel_done) state_nx = ST_EMIT;
			ST_EMIT:     state_nx = ST_LOAD;
			default:     state_nx = ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		cmd           = '0;
		cmd.load      = accept;
		cmd.div_start = state_q == ST_DIV_GO;
		cmd.sel_start = state_q == ST_SEL_GO;
		cmd.emit      = state_q == ST_EMIT;
		busy          = state_q != ST_LOAD;
		done          = state_q == ST_EMIT;
	end

endmodule

// ===== rtl/frame_time_percentile_summary.sv =====
// Items load at one per cycle while busy is low; a run of n kept samples ends
// with the item flagged run_end. After that item is taken, the mean is found
// with one divider step per dividend bit, then the ranks are selected with one
// pass per sample bit over the n stored samples (one store read a cycle).
// Results show for one cycle on done; the receiver cannot stall. arst_n clears
// the run counters and the sequencer; the sample store needs no clearing.
module frame_time_percentile_summary import fts_pkg::*; #(
	parameter int unsigned MAX_SAMPLES = 1024,
	parameter int unsigned SAMPLE_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [OUT_W-1:0]                   sample_us,
	input  logic                               run_end,
	output logic                               done,
	output logic [OUT_W-1:0]                   mean_us,
	output logic [OUT_W-1:0]                   median_us,
	output logic [OUT_W-1:0]                   p95_us,
	output logic [OUT_W-1:0]                   p99_us,
	output logic [OUT_W-1:0]                   best_us,
	output logic [OUT_W-1:0]                   worst_us,
	output logic [$clog2(MAX_SAMPLES+1)-1:0]   sample_count,
	output logic                               overflowed
);

	localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	fts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.run_end (run_end),
		.status  (status),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done)
	);

	fts_datapath #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS),
		.CNT_W       (CNT_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample_us    (sample_us),
		.mean_us      (mean_us),
		.median_us    (median_us),
		.p95_us       (p95_us),
		.p99_us       (p99_us),
		.best_us      (best_us),
		.worst_us     (worst_us),
		.sample_count (sample_count),
		.overflowed   (overflowed)
	);

endmodule

// ===== rtl/fts_checker.sv =====
// fts_checker: port-level checks on the summary block, bound to the top level
// depends on fts_pkg for the field width
module fts_checker import fts_pkg::*; #(
	parameter int unsigned CNT_W = 11
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             run_end,
	input logic             done,
	input logic [CNT_W-1:0] sample_count,
	input logic [OUT_W-1:0] best_us,
	input logic [OUT_W-1:0] worst_us,
	input logic [OUT_W-1:0] median_us
);

	// a result only while the block is working on a run
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe outside a busy period");

	// a plain sample keeps the block open for the next item
	a_plain_open: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !run_end) |=> !busy) else $error("busy after plain item");

	// the last item of a run closes the input
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && run_end) |=> busy) else $error("no busy after run end");

	// after the strobe the block is ready again
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("still busy after result");

	// a result always covers at least one sample and is ordered
	a_result_sane: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (sample_count != '0 && best_us <= median_us && median_us <= worst_us))
		else $error("result out of order or empty");

endmodule

bind frame_time_percentile_summary fts_checker #(
	.CNT_W ($clog2(MAX_SAMPLES + 1))
) u_fts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.run_end      (run_end),
	.done         (done),
	.sample_count (sample_count),
	.best_us      (best_us),
	.worst_us     (worst_us),
	.median_us    (median_us)
);
